>>> hdl/hdub_pkg.sv
`default_nettype none

package hdub_pkg;

  // Ring sizes
  localparam int TX_DEPTH = 64;
  localparam int RX_DEPTH = 8;

  localparam int TX_IDX_W = $clog2(TX_DEPTH);
  localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
  localparam int RX_IDX_W = $clog2(RX_DEPTH);
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

  // Operation codes
  localparam logic [2:0] OP_SEND     = 3'd0;
  localparam logic [2:0] OP_KEY_READ = 3'd1;
  localparam logic [2:0] OP_TX_EMPTY = 3'd2;
  localparam logic [2:0] OP_TX_DONE  = 3'd3;
  localparam logic [2:0] OP_RX_BYTE  = 3'd4;

  // Line enable bits
  localparam int EN_RX   = 0;
  localparam int EN_TX   = 1;
  localparam int EN_UDRE = 2;
  localparam int EN_TXC  = 3;
  localparam logic [3:0] LINE_EN_RESET = 4'b0010;

  // Receive filter constants
  localparam logic [7:0] RX_REJECT   = 8'hF0;
  localparam logic [7:0] RX_LOW_MASK = 8'h0F;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       tx_ninth;
    logic [7:0] tx_byte;
    logic [2:0] op;
  } item_t;

  // Packed from the top bit down, so key sits in the lowest bits
  typedef struct packed {
    logic       transmitter_on;
    logic       receiver_on;
    logic       sending;
    logic       rx_taken;
    logic       tx_dropped;
    logic [8:0] tx_word;
    logic       tx_valid;
    logic       key_valid;
    logic [7:0] key;
  } result_t;

  function automatic logic [TX_IDX_W-1:0] tx_next(input logic [TX_IDX_W-1:0] idx);
    return (idx == TX_IDX_W'(TX_DEPTH - 1)) ? '0 : idx + TX_IDX_W'(1);
  endfunction

  function automatic logic [RX_IDX_W-1:0] rx_next(input logic [RX_IDX_W-1:0] idx);
    return (idx == RX_IDX_W'(RX_DEPTH - 1)) ? '0 : idx + RX_IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

>>> hdl/half_duplex_uart_buffer_controller_unit.sv
// Half-duplex 9-bit serial buffer controller. Each input transfer carries one host access
// (send, key read) or one line event (data empty, transmit complete, received byte) and
// yields exactly one result transfer with the popped key or word and the line status.
// One item is taken every cycle while the result side is ready. A result passes through the
// input register, then the result register, before it is presented; a stalled result holds
// the input register, which then holds in_tready low. The rate is set by the combinational
// update of the ring pointers and counts. Both rings live in RAMs with registered read that
// always prefetch the entry at the read pointer; a write to that same entry is forwarded.
// No clearing pass is needed after reset.
`default_nettype none

module half_duplex_uart_buffer_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // op[2:0], tx_byte[10:3], tx_ninth[11], rx_byte[19:12], zero[23:20]
  input  wire logic [23:0] in_tdata,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // key[7:0], key_valid[8], tx_valid[9], tx_word[18:10], tx_dropped[19], rx_taken[20],
  // sending[21], receiver_on[22], transmitter_on[23]
  output      logic [23:0] out_tdata
);

  localparam int TX_IDX_W    = hdub_pkg::TX_IDX_W;
  localparam int TX_CNT_W    = hdub_pkg::TX_CNT_W;
  localparam int RX_IDX_W    = hdub_pkg::RX_IDX_W;
  localparam int RX_CNT_W    = hdub_pkg::RX_CNT_W;
  localparam int OUT_TDATA_W = hdub_pkg::OUT_TDATA_W;

  // Pipeline registers
  logic                s1_valid_r;
  hdub_pkg::item_t     s1_item_r;
  logic                out_valid_r;
  hdub_pkg::result_t   result_r;
  hdub_pkg::result_t   result_nxt;
  logic                advance;
  logic                fire;

  // Ring state
  logic [TX_IDX_W-1:0] tx_head_r, tx_head_nxt;
  logic [TX_IDX_W-1:0] tx_tail_r, tx_tail_nxt;
  logic [TX_CNT_W-1:0] tx_count_r, tx_count_nxt;
  logic [RX_IDX_W-1:0] rx_head_r, rx_head_nxt;
  logic [RX_IDX_W-1:0] rx_tail_r, rx_tail_nxt;
  logic [RX_CNT_W-1:0] rx_count_r, rx_count_nxt;
  logic                sending_r, sending_nxt;
  logic [3:0]          line_en_r, line_en_nxt;

  // Transmit RAM ports and forwarding
  logic                tx_wr_en;
  logic [8:0]          tx_wr_word;
  logic [8:0]          ram_q;
  logic                byp_r;
  logic [8:0]          byp_word_r;
  logic [8:0]          tx_head_word;

  // Receive RAM ports and forwarding
  logic                rx_wr_en;
  logic [7:0]          rx_q;
  logic                rx_byp_r;
  logic [7:0]          rx_byp_word_r;
  logic [7:0]          rx_tail_word;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      s1_item_r <= hdub_pkg::item_t'(in_tdata[19:0]);
    end
  end

  assign tx_head_word = byp_r ? byp_word_r : ram_q;
  assign tx_wr_word   = {s1_item_r.tx_ninth, s1_item_r.tx_byte};
  assign rx_tail_word = rx_byp_r ? rx_byp_word_r : rx_q;

  // Work out one item
  always_comb begin
    tx_head_nxt  = tx_head_r;
    tx_tail_nxt  = tx_tail_r;
    tx_count_nxt = tx_count_r;
    rx_head_nxt  = rx_head_r;
    rx_tail_nxt  = rx_tail_r;
    rx_count_nxt = rx_count_r;
    sending_nxt  = sending_r;
    line_en_nxt  = line_en_r;
    tx_wr_en     = 1'b0;
    rx_wr_en     = 1'b0;
    result_nxt   = '0;
    if (fire) begin
      unique case (s1_item_r.op)
        hdub_pkg::OP_SEND: begin
          if (tx_count_r != TX_CNT_W'(hdub_pkg::TX_DEPTH)) begin
            tx_wr_en     = 1'b1;
            tx_count_nxt = tx_count_r + TX_CNT_W'(1);
            tx_head_nxt  = hdub_pkg::tx_next(tx_head_r);
          end else begin
            result_nxt.tx_dropped = 1'b1;
          end
          if (!sending_r) begin
            sending_nxt                    = 1'b1;
            line_en_nxt[hdub_pkg::EN_RX]   = 1'b0;
            line_en_nxt[hdub_pkg::EN_TX]   = 1'b1;
            line_en_nxt[hdub_pkg::EN_UDRE] = 1'b1;
          end
        end
        hdub_pkg::OP_KEY_READ: begin
          if (rx_count_r != '0) begin
            result_nxt.key       = rx_tail_word;
            result_nxt.key_valid = 1'b1;
            rx_count_nxt         = rx_count_r - RX_CNT_W'(1);
            rx_tail_nxt          = hdub_pkg::rx_next(rx_tail_r);
          end
        end
        hdub_pkg::OP_TX_EMPTY: begin
          if (line_en_r[hdub_pkg::EN_UDRE]) begin
            if (tx_count_r != '0) begin
              result_nxt.tx_word  = tx_head_word;
              result_nxt.tx_valid = 1'b1;
              tx_count_nxt        = tx_count_r - TX_CNT_W'(1);
              tx_tail_nxt         = hdub_pkg::tx_next(tx_tail_r);
            end else begin
              line_en_nxt[hdub_pkg::EN_UDRE] = 1'b0;
              line_en_nxt[hdub_pkg::EN_TXC]  = 1'b1;
              sending_nxt                    = 1'b0;
            end
          end
        end
        hdub_pkg::OP_TX_DONE: begin
          if (line_en_r[hdub_pkg::EN_TXC]) begin
            line_en_nxt[hdub_pkg::EN_TX]  = 1'b0;
            line_en_nxt[hdub_pkg::EN_TXC] = 1'b0;
            line_en_nxt[hdub_pkg::EN_RX]  = 1'b1;
            rx_head_nxt                   = '0;
            rx_tail_nxt                   = '0;
            rx_count_nxt                  = '0;
          end
        end
        hdub_pkg::OP_RX_BYTE: begin
          if (line_en_r[hdub_pkg::EN_RX] && s1_item_r.rx_byte != hdub_pkg::RX_REJECT
              && (s1_item_r.rx_byte & hdub_pkg::RX_LOW_MASK) == '0
              && rx_count_r != RX_CNT_W'(hdub_pkg::RX_DEPTH)) begin
            rx_wr_en            = 1'b1;
            rx_count_nxt        = rx_count_r + RX_CNT_W'(1);
            rx_head_nxt         = hdub_pkg::rx_next(rx_head_r);
            result_nxt.rx_taken = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    result_nxt.sending        = sending_nxt;
    result_nxt.receiver_on    = line_en_nxt[hdub_pkg::EN_RX];
    result_nxt.transmitter_on = line_en_nxt[hdub_pkg::EN_TX];
  end

  // Advance ring and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r  <= '0;
      tx_tail_r  <= '0;
      tx_count_r <= '0;
      rx_head_r  <= '0;
      rx_tail_r  <= '0;
      rx_count_r <= '0;
      sending_r  <= 1'b0;
      line_en_r  <= hdub_pkg::LINE_EN_RESET;
      byp_r      <= 1'b0;
      rx_byp_r   <= 1'b0;
    end else begin
      tx_head_r  <= tx_head_nxt;
      tx_tail_r  <= tx_tail_nxt;
      tx_count_r <= tx_count_nxt;
      rx_head_r  <= rx_head_nxt;
      rx_tail_r  <= rx_tail_nxt;
      rx_count_r <= rx_count_nxt;
      sending_r  <= sending_nxt;
      line_en_r  <= line_en_nxt;
      byp_r      <= tx_wr_en && (tx_head_r == tx_tail_nxt);
      rx_byp_r   <= rx_wr_en && (rx_head_r == rx_tail_nxt);
    end
    byp_word_r    <= tx_wr_word;
    rx_byp_word_r <= s1_item_r.rx_byte;
  end

  // Transmit ring, prefetching the entry at the next read pointer
  hdub_ram #(
    .WIDTH (9),
    .DEPTH (hdub_pkg::TX_DEPTH)
  ) u_tx_ram (
    .clk     (clk),
    .wr_en   (tx_wr_en),
    .wr_addr (tx_head_r),
    .wr_data (tx_wr_word),
    .rd_addr (tx_tail_nxt),
    .rd_data (ram_q)
  );

  // Receive ring, prefetching the entry at the next read pointer
  hdub_ram #(
    .WIDTH (8),
    .DEPTH (hdub_pkg::RX_DEPTH)
  ) u_rx_ram (
    .clk     (clk),
    .wr_en   (rx_wr_en),
    .wr_addr (rx_head_r),
    .wr_data (s1_item_r.rx_byte),
    .rd_addr (rx_tail_nxt),
    .rd_data (rx_q)
  );

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
    if (fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(result_r);

endmodule

`default_nettype wire

>>> hdl/hdub_ram.sv
`default_nettype none

module hdub_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> tb/sv/tb_half_duplex_uart_buffer_controller_unit.sv
`timescale 1ns / 100ps

module tb_half_duplex_uart_buffer_controller_unit;

  // Op codes the block ignores
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int ITEM_TARGET = 800;
  localparam int QUIET_LIMIT = 500;
  localparam int ITEM_W      = $bits(hdub_pkg::item_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [hdub_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [hdub_pkg::OUT_TDATA_W-1:0] out_tdata;

  half_duplex_uart_buffer_controller_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Own copy of the buffer state
  logic [8:0] tx_ring [hdub_pkg::TX_DEPTH];
  int         tx_wr = 0;
  int         tx_rd = 0;
  int         tx_fill = 0;
  logic [7:0] rx_ring [hdub_pkg::RX_DEPTH];
  int         rx_wr = 0;
  int         rx_rd = 0;
  int         rx_fill = 0;
  logic       line_busy = 1'b0;
  logic [3:0] line_en = hdub_pkg::LINE_EN_RESET;

  hdub_pkg::item_t   pending_items [$];
  hdub_pkg::result_t owed_results [$];
  int                live_items = 0;
  int                fail_count = 0;

  int          burst_left = 1;
  int          gap_left = 0;
  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_age = 0;
  int          quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Work out the status and popped data for one accepted transfer
  task automatic advance_buffers(input hdub_pkg::item_t it);
    hdub_pkg::result_t r;
    r = '0;
    case (it.op)
      hdub_pkg::OP_SEND: begin
        if (tx_fill < hdub_pkg::TX_DEPTH) begin
          tx_ring[tx_wr] = {it.tx_ninth, it.tx_byte};
          tx_fill++;
          tx_wr = (tx_wr + 1) % hdub_pkg::TX_DEPTH;
        end else begin
          r.tx_dropped = 1'b1;
        end
        // first send switches the line to transmit
        if (!line_busy) begin
          line_busy = 1'b1;
          line_en[hdub_pkg::EN_RX] = 1'b0;
          line_en[hdub_pkg::EN_TX] = 1'b1;
          line_en[hdub_pkg::EN_UDRE] = 1'b1;
        end
      end
      hdub_pkg::OP_KEY_READ: begin
        if (rx_fill != 0) begin
          r.key = rx_ring[rx_rd];
          r.key_valid = 1'b1;
          rx_fill--;
          rx_rd = (rx_rd + 1) % hdub_pkg::RX_DEPTH;
        end
      end
      hdub_pkg::OP_TX_EMPTY: begin
        if (line_en[hdub_pkg::EN_UDRE]) begin
          if (tx_fill != 0) begin
            r.tx_word = tx_ring[tx_rd];
            r.tx_valid = 1'b1;
            tx_fill--;
            tx_rd = (tx_rd + 1) % hdub_pkg::TX_DEPTH;
          end else begin
            line_en[hdub_pkg::EN_UDRE] = 1'b0;
            line_en[hdub_pkg::EN_TXC] = 1'b1;
            line_busy = 1'b0;
          end
        end
      end
      hdub_pkg::OP_TX_DONE: begin
        if (line_en[hdub_pkg::EN_TXC]) begin
          line_en[hdub_pkg::EN_TX] = 1'b0;
          line_en[hdub_pkg::EN_TXC] = 1'b0;
          line_en[hdub_pkg::EN_RX] = 1'b1;
          rx_wr = 0;
          rx_rd = 0;
          rx_fill = 0;
        end
      end
      hdub_pkg::OP_RX_BYTE: begin
        if (line_en[hdub_pkg::EN_RX] && it.rx_byte != hdub_pkg::RX_REJECT
            && (it.rx_byte & hdub_pkg::RX_LOW_MASK) == '0
            && rx_fill < hdub_pkg::RX_DEPTH) begin
          rx_ring[rx_wr] = it.rx_byte;
          rx_fill++;
          rx_wr = (rx_wr + 1) % hdub_pkg::RX_DEPTH;
          r.rx_taken = 1'b1;
        end
      end
      default: ;
    endcase
    r.sending = line_busy;
    r.receiver_on = line_en[hdub_pkg::EN_RX];
    r.transmitter_on = line_en[hdub_pkg::EN_TX];
    owed_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(input hdub_pkg::result_t got);
    hdub_pkg::result_t want;
    if (owed_results.size() == 0) begin
      $display("%0t: result with nothing outstanding, expected none, actual 'h%0h",
               $time, got);
      fail_count++;
    end else begin
      want = owed_results.pop_front();
      compare_field("key", want.key, got.key);
      compare_field("key_valid", want.key_valid, got.key_valid);
      compare_field("tx_valid", want.tx_valid, got.tx_valid);
      compare_field("tx_word", want.tx_word, got.tx_word);
      compare_field("tx_dropped", want.tx_dropped, got.tx_dropped);
      compare_field("rx_taken", want.rx_taken, got.rx_taken);
      compare_field("sending", want.sending, got.sending);
      compare_field("receiver_on", want.receiver_on, got.receiver_on);
      compare_field("transmitter_on", want.transmitter_on, got.transmitter_on);
    end
  endtask

  task automatic add_item(input logic [2:0] op, input logic [7:0] txb, input logic nin,
                          input logic [7:0] rxb);
    hdub_pkg::item_t it;
    it.op = op;
    it.tx_byte = txb;
    it.tx_ninth = nin;
    it.rx_byte = rxb;
    pending_items.push_back(it);
    live_items++;
  endtask

  // Fully random item, any op code
  task automatic add_noise();
    hdub_pkg::item_t it;
    it.op = 3'($urandom_range(0, 7));
    it.tx_byte = 8'($urandom);
    it.tx_ninth = 1'($urandom);
    it.rx_byte = 8'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic add_send();
    add_item(hdub_pkg::OP_SEND, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // Sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_buffers(hdub_pkg::item_t'(in_tdata[ITEM_W-1:0]));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_tdata <= {{(hdub_pkg::IN_TDATA_W - ITEM_W){1'b0}}, pending_items.pop_front()};
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transfer, stall on a rotating pattern reloaded now and then
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_result(hdub_pkg::result_t'(out_tdata));
    end
    out_tready <= ready_pat[0];
    if (pat_age == 63) begin
      pat_age <= 0;
      ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end else begin
      pat_age <= pat_age + 1;
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    int pops;
    int m;
    logic [2:0] spare;

    // Idle line, empty rings, disarmed events
    add_item(hdub_pkg::OP_KEY_READ, 8'h00, 1'b0, 8'h00);
    add_item(hdub_pkg::OP_TX_EMPTY, 8'h00, 1'b0, 8'h00);
    add_item(hdub_pkg::OP_TX_DONE, 8'h00, 1'b0, 8'h00);
    add_item(hdub_pkg::OP_RX_BYTE, 8'h00, 1'b0, 8'h00);
    for (spare = OP_SPARE_LO; spare != OP_SPARE_HI; spare++) begin
      add_item(spare, 8'hFF, 1'b1, 8'hFF);
    end
    add_item(OP_SPARE_HI, 8'hFF, 1'b1, 8'hFF);
    // Send, drain, switch to receive
    add_item(hdub_pkg::OP_SEND, 8'hFF, 1'b1, 8'hFF);
    add_item(hdub_pkg::OP_SEND, 8'h00, 1'b0, 8'h00);
    add_item(hdub_pkg::OP_TX_EMPTY, 8'h00, 1'b0, 8'h00);
    add_item(hdub_pkg::OP_TX_EMPTY, 8'h00, 1'b0, 8'h00);
    add_item(hdub_pkg::OP_TX_EMPTY, 8'h00, 1'b0, 8'h00);
    add_item(hdub_pkg::OP_TX_EMPTY, 8'h00, 1'b0, 8'h00);
    add_item(hdub_pkg::OP_TX_DONE, 8'h00, 1'b0, 8'h00);
    // Receive filter: reject byte, non-zero low nibble, then two keepers
    add_item(hdub_pkg::OP_RX_BYTE, 8'h00, 1'b0, hdub_pkg::RX_REJECT);
    add_item(hdub_pkg::OP_RX_BYTE, 8'h00, 1'b0, hdub_pkg::RX_LOW_MASK);
    add_item(hdub_pkg::OP_RX_BYTE, 8'h00, 1'b0, 8'h00);
    add_item(hdub_pkg::OP_RX_BYTE, 8'h00, 1'b0, 8'hA0);
    add_item(hdub_pkg::OP_KEY_READ, 8'h00, 1'b0, 8'h00);
    add_item(hdub_pkg::OP_KEY_READ, 8'h00, 1'b0, 8'h00);
    add_item(hdub_pkg::OP_KEY_READ, 8'h00, 1'b0, 8'h00);
    add_item(hdub_pkg::OP_TX_DONE, 8'h00, 1'b0, 8'h00);
    add_item(hdub_pkg::OP_SEND, 8'h55, 1'b1, 8'hAA);

    // Random sessions: send a batch, drain it, hand over to receive, read keys
    while (live_items < ITEM_TARGET) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        add_send();
        if ($urandom_range(0, 7) == 0) add_noise();
      end
      pops = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : n + 1;
      for (int i = 0; i < pops; i++) begin
        add_item(hdub_pkg::OP_TX_EMPTY, 8'($urandom), 1'($urandom), 8'($urandom));
        if ($urandom_range(0, 9) == 0) add_noise();
      end
      if ($urandom_range(0, 7) != 0) begin
        add_item(hdub_pkg::OP_TX_DONE, 8'($urandom), 1'($urandom), 8'($urandom));
      end
      m = $urandom_range(0, 14);
      for (int i = 0; i < m; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          add_item(hdub_pkg::OP_RX_BYTE, 8'($urandom), 1'($urandom), 8'($urandom));
        end else begin
          add_item(hdub_pkg::OP_RX_BYTE, 8'($urandom), 1'($urandom),
                   {4'($urandom), 4'h0});
        end
        if ($urandom_range(0, 3) == 0) add_item(hdub_pkg::OP_KEY_READ, 8'($urandom),
                                                1'($urandom), 8'($urandom));
      end
      m = $urandom_range(0, 8);
      for (int i = 0; i < m; i++) begin
        add_item(hdub_pkg::OP_KEY_READ, 8'($urandom), 1'($urandom), 8'($urandom));
      end
    end

    // Hold reset, then release and let the driver run
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (owed_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, owed_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
